>>> rtl/rmtwm_pkg.sv
package rmtwm_pkg;

  // channel and window geometry
  localparam int NCH      = 3;
  localparam int WIN      = 9;
  localparam int COL_PIX  = 3;
  localparam int CHAIN    = WIN - 1;
  localparam int CENTER   = 4;
  localparam int MED_RANK = 4;

  // floor(x/10) as (x*205) >> 11, exact for x below 1024
  localparam int RECIP  = 205;
  localparam int RSHIFT = 11;

  typedef logic [7:0]           chan_t;
  typedef logic [NCH-1:0][7:0]  pix_t;
  typedef logic [WIN-1:0][7:0]  win_t;
  typedef logic [WIN-1:0]       sel_t;
  typedef logic [3:0]           rank_t;

  function automatic logic [5:0] div10(input logic [8:0] x);
    logic [16:0] prod;
    prod = 17'(x) * 17'(RECIP);
    return prod[RSHIFT +: 6];
  endfunction

endpackage

>>> rtl/rgb_median_then_weighted_mean_3x3_core.sv
// RGB 3x3 median-then-weighted-mean filter.
//
// Input channel: red/green/blue/full_window with in_valid and in_stall; a word
// is taken at a clock edge with in_valid high and in_stall low. Words come in
// groups: nine pixels of a full window in row-major order (full_window high on
// the first word) or three pixels of a new right column, top to bottom
// (full_window low on the first word). Two saved columns per channel supply
// the rest of the window for a column group.
// Output channel: out_red/out_green/out_blue with out_valid and out_stall; one
// word per completed group.
// Throughput: one input word per cycle while in_stall is low, set by the gather
// chain shifting on every accept; a group, and so a result, takes at least three
// input words. The result passes through three registers, the first loaded at the edge
// that takes the group's last pixel: window capture, rank/partial-sum stage, output register.
// Reset (rst, synchronous): saved columns clear to zero, group position and
// all stage valids clear. When out_stall holds the output, the two inner
// stages keep filling; in_stall rises only once all three are occupied.
module rgb_median_then_weighted_mean_3x3_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       full_window,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  rmtwm_pkg::pix_t  in_pix;
  rmtwm_pkg::pix_t  cell_q [rmtwm_pkg::CHAIN];
  rmtwm_pkg::pix_t  col_pix [rmtwm_pkg::COL_PIX];
  rmtwm_pkg::chan_t saved [rmtwm_pkg::NCH][rmtwm_pkg::COL_PIX][2];
  rmtwm_pkg::win_t  win [rmtwm_pkg::NCH];

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [3:0] need_last;
  logic       grp_full;
  logic       full_now;
  logic       last;
  logic       accept;
  logic       done;

  logic             s1_valid;
  rmtwm_pkg::win_t  s1_win [rmtwm_pkg::NCH];
  logic             s2_valid;
  rmtwm_pkg::win_t  s2_win [rmtwm_pkg::NCH];
  rmtwm_pkg::sel_t  s2_sel [rmtwm_pkg::NCH];
  logic [7:0]       s2_psum [rmtwm_pkg::NCH];
  rmtwm_pkg::sel_t  rank_sel [rmtwm_pkg::NCH];
  logic [7:0]       psum [rmtwm_pkg::NCH];
  rmtwm_pkg::chan_t med [rmtwm_pkg::NCH];
  logic [7:0]       res [rmtwm_pkg::NCH];

  logic out_move;
  logic s2_en;
  logic s1_en;

  assign in_pix = {blue, green, red};

  // stage flow: each stage moves when the one after it has room
  assign out_move = !out_valid || !out_stall;
  assign s2_en    = !s2_valid || out_move;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;
  assign accept   = in_valid && !in_stall;

  // group position and kind
  assign full_now  = (pos == '0) ? full_window : grp_full;
  assign need_last = full_now ? 4'(rmtwm_pkg::WIN - 1) : 4'(rmtwm_pkg::COL_PIX - 1);
  assign last      = (pos == need_last);
  assign done      = accept && last;
  assign pos_next  = last ? '0 : pos + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      grp_full <= 1'b0;
    end else if (accept) begin
      pos      <= pos_next;
      grp_full <= full_now;
    end
  end

  // gather chain: cell 0 holds the newest pixel
  for (genvar i = 0; i < rmtwm_pkg::CHAIN; i++) begin : g_chain
    if (i == 0) begin : g_head
      rmtwm_cell u_cell (.clk(clk), .shift(accept), .d(in_pix), .q(cell_q[i]));
    end else begin : g_body
      rmtwm_cell u_cell (.clk(clk), .shift(accept), .d(cell_q[i-1]), .q(cell_q[i]));
    end
  end

  // window as seen with the incoming pixel completing the group
  assign col_pix[0] = cell_q[1];
  assign col_pix[1] = cell_q[0];
  assign col_pix[2] = in_pix;

  always_comb begin
    for (int c = 0; c < rmtwm_pkg::NCH; c++) begin
      if (full_now) begin
        for (int k = 0; k < rmtwm_pkg::CHAIN; k++) begin
          win[c][k] = cell_q[rmtwm_pkg::CHAIN - 1 - k][c];
        end
        win[c][rmtwm_pkg::WIN - 1] = in_pix[c];
      end else begin
        for (int r = 0; r < rmtwm_pkg::COL_PIX; r++) begin
          win[c][r*3 + 0] = saved[c][r][0];
          win[c][r*3 + 1] = saved[c][r][1];
          win[c][r*3 + 2] = col_pix[r][c];
        end
      end
    end
  end

  // keep the window's two right columns, unfiltered
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < rmtwm_pkg::NCH; c++) begin
        for (int r = 0; r < rmtwm_pkg::COL_PIX; r++) begin
          saved[c][r][0] <= '0;
          saved[c][r][1] <= '0;
        end
      end
    end else if (done) begin
      for (int c = 0; c < rmtwm_pkg::NCH; c++) begin
        for (int r = 0; r < rmtwm_pkg::COL_PIX; r++) begin
          saved[c][r][0] <= win[c][r*3 + 1];
          saved[c][r][1] <= win[c][r*3 + 2];
        end
      end
    end
  end

  // stage 1: window capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      s1_win <= win;
    end
  end

  // stage 2: median select and sum of the eight outer tenths
  for (genvar c = 0; c < rmtwm_pkg::NCH; c++) begin : g_rank
    rmtwm_rank u_rank (.vals(s1_win[c]), .sel(rank_sel[c]));
  end

  always_comb begin
    for (int c = 0; c < rmtwm_pkg::NCH; c++) begin
      psum[c] = '0;
      for (int k = 0; k < rmtwm_pkg::WIN; k++) begin
        if (k != rmtwm_pkg::CENTER) begin
          psum[c] = psum[c] + {2'b00, rmtwm_pkg::div10({1'b0, s1_win[c][k]})};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      s2_win  <= s1_win;
      s2_sel  <= rank_sel;
      s2_psum <= psum;
    end
  end

  // output stage: add the doubled median's tenth
  always_comb begin
    for (int c = 0; c < rmtwm_pkg::NCH; c++) begin
      med[c] = '0;
      for (int i = 0; i < rmtwm_pkg::WIN; i++) begin
        med[c] = med[c] | ({8{s2_sel[c][i]}} & s2_win[c][i]);
      end
      res[c] = s2_psum[c] + {2'b00, rmtwm_pkg::div10({med[c], 1'b0})};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s2_valid) begin
      out_red   <= res[0];
      out_green <= res[1];
      out_blue  <= res[2];
    end
  end

endmodule

>>> rtl/rmtwm_cell.sv
// One pixel slot of the gather chain; takes its d word on each accept.
module rmtwm_cell (
  input  logic             clk,
  input  logic             shift,
  input  rmtwm_pkg::pix_t  d,
  output rmtwm_pkg::pix_t  q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

>>> rtl/rmtwm_rank.sv
// Picks the median of nine values of one channel as a one-hot select.
// Rank = number of values below, ties broken by position, so exactly one
// entry has rank four.
module rmtwm_rank (
  input  rmtwm_pkg::win_t  vals,
  output rmtwm_pkg::sel_t  sel
);

  rmtwm_pkg::rank_t cnt [rmtwm_pkg::WIN];

  always_comb begin
    for (int i = 0; i < rmtwm_pkg::WIN; i++) begin
      cnt[i] = '0;
      for (int j = 0; j < rmtwm_pkg::WIN; j++) begin
        if (j != i) begin
          if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
            cnt[i] = cnt[i] + 4'd1;
          end
        end
      end
      sel[i] = (cnt[i] == 4'(rmtwm_pkg::MED_RANK));
    end
  end

endmodule

>>> rtl/rmtwm_checker.sv
// Port-level checks for the filter core.
module rmtwm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // input backs up only when a result is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(out_red) && $stable(out_green) &&
                                  $stable(out_blue)))
    else $error("stalled result changed");

endmodule

bind rgb_median_then_weighted_mean_3x3_core rmtwm_checker u_rmtwm_checker (.*);

>>> verif/rgb_median_then_weighted_mean_3x3_core_test.sv
`timescale 1ns / 1ps

module rgb_median_then_weighted_mean_3x3_core_test;

  typedef struct packed {
    rmtwm_pkg::chan_t red;
    rmtwm_pkg::chan_t green;
    rmtwm_pkg::chan_t blue;
    logic             full_window;
  } pixel_word_t;

  typedef struct packed {
    rmtwm_pkg::chan_t red;
    rmtwm_pkg::chan_t green;
    rmtwm_pkg::chan_t blue;
  } rgb_word_t;

  localparam int RANDOM_PIXELS = 750;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_LEN      = 400;
  localparam int HOLD_PERIOD   = 1500;
  localparam int DRAIN_CYCLES  = 20;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  // block ports
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] red         = '0;
  logic [7:0] green       = '0;
  logic [7:0] blue        = '0;
  logic       full_window = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  rgb_median_then_weighted_mean_3x3_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .full_window (full_window),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

  pixel_word_t pending_q[$];
  rgb_word_t   filtered_q[$];
  int          errors = 0;
  logic        in_fire = 1'b0;

  // filter model state
  rmtwm_pkg::chan_t saved_col [rmtwm_pkg::NCH][3][2];
  rmtwm_pkg::chan_t gathered [rmtwm_pkg::WIN][rmtwm_pkg::NCH];
  int    grp_pos;
  bit    grp_full;

  function automatic rmtwm_pkg::chan_t median9(input rmtwm_pkg::win_t v);
    rmtwm_pkg::win_t  s;
    rmtwm_pkg::chan_t t;
    s = v;
    for (int i = 0; i < rmtwm_pkg::WIN - 1; i++) begin
      for (int j = 0; j < rmtwm_pkg::WIN - 1 - i; j++) begin
        if (s[j] > s[j+1]) begin
          t      = s[j];
          s[j]   = s[j+1];
          s[j+1] = t;
        end
      end
    end
    return s[rmtwm_pkg::MED_RANK];
  endfunction

  // gather one pixel; returns 1 with the filtered pixel when a group completes
  function automatic bit filter_pixel(input pixel_word_t w, output rgb_word_t res);
    rmtwm_pkg::chan_t pix [rmtwm_pkg::NCH];
    rmtwm_pkg::win_t  win [rmtwm_pkg::NCH];
    int               need;
    int unsigned      wgt;
    int unsigned      sum [rmtwm_pkg::NCH];
    res    = '0;
    pix[0] = w.red;
    pix[1] = w.green;
    pix[2] = w.blue;
    if (grp_pos == 0) grp_full = w.full_window;
    need = grp_full ? rmtwm_pkg::WIN : rmtwm_pkg::COL_PIX;
    if (grp_pos >= need) grp_pos = 0;
    for (int c = 0; c < rmtwm_pkg::NCH; c++) gathered[grp_pos][c] = pix[c];
    grp_pos++;
    if (grp_pos < need) return 1'b0;
    grp_pos = 0;

    // build the window and save its two right columns, unfiltered
    for (int c = 0; c < rmtwm_pkg::NCH; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (grp_full) begin
          for (int k = 0; k < 3; k++) win[c][r*3+k] = gathered[r*3+k][c];
        end else begin
          win[c][r*3]   = saved_col[c][r][0];
          win[c][r*3+1] = saved_col[c][r][1];
          win[c][r*3+2] = gathered[r][c];
        end
      end
      for (int r = 0; r < 3; r++) begin
        saved_col[c][r][0] = win[c][r*3+1];
        saved_col[c][r][1] = win[c][r*3+2];
      end
    end

    // median into the center, then weighted floor sum
    for (int c = 0; c < rmtwm_pkg::NCH; c++) begin
      win[c][rmtwm_pkg::CENTER] = median9(win[c]);
      sum[c] = 0;
      for (int k = 0; k < rmtwm_pkg::WIN; k++) begin
        wgt = (k == rmtwm_pkg::CENTER) ? 2 : 1;
        sum[c] += (32'(win[c][k]) * wgt) / 10;
      end
    end
    res.red   = sum[0][7:0];
    res.green = sum[1][7:0];
    res.blue  = sum[2][7:0];
    return 1'b1;
  endfunction

  // gap lengths: mostly short, a few long, none inside a burst
  function automatic int idle_len(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rmtwm_pkg::chan_t rand_chan(input int style,
                                                 input rmtwm_pkg::chan_t base);
    int r;
    r = $urandom_range(0, 7);
    case (style)
      0: begin
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return rmtwm_pkg::chan_t'($urandom_range(0, 255));
      end
      1: return base ^ rmtwm_pkg::chan_t'($urandom_range(0, 7));
      default: return (r < 4) ? 8'd0 : 8'd255;
    endcase
  endfunction

  task automatic queue_pixel(input rmtwm_pkg::chan_t r, input rmtwm_pkg::chan_t g,
                             input rmtwm_pkg::chan_t b, input logic fw);
    pixel_word_t w;
    w.red         = r;
    w.green       = g;
    w.blue        = b;
    w.full_window = fw;
    pending_q.push_back(w);
  endtask

  // one well-formed group with random content; returns its word count
  task automatic queue_random_group(output int words);
    bit               full;
    int               style;
    rmtwm_pkg::chan_t base [rmtwm_pkg::NCH];
    full  = ($urandom_range(0, 2) == 0);
    style = $urandom_range(0, 2);
    for (int c = 0; c < rmtwm_pkg::NCH; c++) begin
      base[c] = rmtwm_pkg::chan_t'($urandom_range(0, 255));
    end
    words = full ? rmtwm_pkg::WIN : rmtwm_pkg::COL_PIX;
    for (int i = 0; i < words; i++) begin
      queue_pixel(rand_chan(style, base[0]), rand_chan(style, base[1]),
                  rand_chan(style, base[2]),
                  (i == 0) ? full : logic'($urandom_range(0, 1)));
    end
  endtask

  task automatic check_chan(input string name, input rmtwm_pkg::chan_t want,
                            input rmtwm_pkg::chan_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // sender: holds a stalled word, then idles a random gap before the next one
  int tx_wait  = 0;
  int tx_burst = 0;
  always @(negedge clk) begin
    pixel_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        red         <= nxt.red;
        green       <= nxt.green;
        blue        <= nxt.blue;
        full_window <= nxt.full_window;
        in_valid    <= 1'b1;
        if (tx_burst > 0) tx_burst--;
        else if ($urandom_range(0, 19) == 0) tx_burst = $urandom_range(20, 80);
        tx_wait = idle_len(tx_burst != 0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall runs plus a periodic long hold-off
  int rx_cycle  = 0;
  int rx_wait   = 0;
  int hold_left = 0;
  int rx_burst  = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_cycle % HOLD_PERIOD == 300) begin
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (rx_burst > 0) rx_burst--;
        else if ($urandom_range(0, 29) == 0) rx_burst = $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) rx_wait = idle_len(rx_burst != 0);
      end
    end
  end

  // monitor: predict on each accepted input word, check each accepted result
  always @(posedge clk) begin
    rgb_word_t   got;
    rgb_word_t   want;
    pixel_word_t w;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got.red   = out_red;
        got.green = out_green;
        got.blue  = out_blue;
        if (filtered_q.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d",
                 got.red, got.green, got.blue);
          errors++;
        end else begin
          want = filtered_q.pop_front();
          check_chan("out_red", want.red, got.red);
          check_chan("out_green", want.green, got.green);
          check_chan("out_blue", want.blue, got.blue);
        end
      end
      if (in_valid && !in_stall) begin
        w.red         = red;
        w.green       = green;
        w.blue        = blue;
        w.full_window = full_window;
        if (filter_pixel(w, want)) filtered_q.push_back(want);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("rgb_median_then_weighted_mean_3x3_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int queued;
    int words;
    for (int c = 0; c < rmtwm_pkg::NCH; c++)
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 2; k++) saved_col[c][r][k] = '0;
    for (int i = 0; i < rmtwm_pkg::WIN; i++)
      for (int c = 0; c < rmtwm_pkg::NCH; c++) gathered[i][c] = '0;
    grp_pos  = 0;
    grp_full = 1'b0;

    // column before any window, against the reset zeros; flag ignored after first
    queue_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    queue_pixel(8'd255, 8'd255, 8'd0, 1'b1);
    // full window at the top value: largest sum
    for (int i = 0; i < rmtwm_pkg::WIN; i++) begin
      queue_pixel(8'd255, 8'd255, 8'd255, (i == 0));
    end
    // all-zero column shifted into the saved columns
    for (int i = 0; i < rmtwm_pkg::COL_PIX; i++) begin
      queue_pixel(8'd0, 8'd0, 8'd0, (i != 0));
    end
    // full window with red descending, green and blue ascending, an outlier blue center, flag low after first
    for (int i = 0; i < rmtwm_pkg::WIN; i++) begin
      queue_pixel(rmtwm_pkg::chan_t'(250 - i * 30), rmtwm_pkg::chan_t'(i * 28),
                  (i == rmtwm_pkg::CENTER) ? 8'd255 : rmtwm_pkg::chan_t'(i * 3),
                  (i == 0));
    end

    // random well-formed groups
    queued = 0;
    while (queued < RANDOM_PIXELS) begin
      queue_random_group(words);
      queued += words;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && filtered_q.size() == 0) begin
      $display("rgb_median_then_weighted_mean_3x3_core test passed");
    end else begin
      $display("rgb_median_then_weighted_mean_3x3_core test failed");
    end
    $finish;
  end

endmodule
